// ===== rtl/core/umc_pkg.sv =====
// shared widths and codes for the unique address collector
package umc_pkg;

    // field widths
    localparam int unsigned FRAME_TYPE_W = 2;
    localparam int unsigned ADDR_W       = 48;
    localparam int unsigned PKT_NUM_W    = 6;

    // default sizing
    localparam int unsigned UMC_TABLE_DEPTH        = 32;
    localparam int unsigned UMC_ENTRIES_PER_PACKET = 21;

    // frame type codes
    typedef logic [FRAME_TYPE_W-1:0] frame_type_t;
    localparam frame_type_t FT_MANAGEMENT = 2'd0;
    localparam frame_type_t FT_CONTROL    = 2'd1;
    localparam frame_type_t FT_DATA       = 2'd2;
    localparam frame_type_t FT_EXTENSION  = 2'd3;

endpackage

// ===== rtl/core/umc_if.sv =====
// frame and flushed-entry channel interfaces

interface umc_frame_if import umc_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [FRAME_TYPE_W-1:0] frame_type;
    logic [ADDR_W-1:0]       source_address;

    modport source (output valid, output frame_type, output source_address, input ready);
    modport sink   (input valid, input frame_type, input source_address, output ready);
endinterface

interface umc_entry_if import umc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [ADDR_W-1:0]    entry_address;
    logic [PKT_NUM_W-1:0] packet_number;
    logic                 chained_flag;
    logic                 last_in_packet;
    logic                 last_of_flush;

    modport source (output valid, output entry_address, output packet_number,
                    output chained_flag, output last_in_packet, output last_of_flush,
                    input ready);
    modport sink   (input valid, input entry_address, input packet_number,
                    input chained_flag, input last_in_packet, input last_of_flush,
                    output ready);
endinterface

// ===== rtl/core/unique_mac_collector_batch_flush.sv =====
// top level: address table search, append and packetized flush
//
// Each frame whose type is management, control or data has its transmitter address
// searched in a table of distinct addresses held in a single ram; a new address is
// appended, and the next frame is not taken until it is written. The search reads
// one stored entry per cycle through the ram's single read port and compares each
// read with the frame's address; after the last read is compared, S_APPEND writes
// the new entry. A known address ends the search at its match and gives no output.
// Extension frames are taken without a search and give no output. When an append
// fills the table, all TABLE_DEPTH entries stream out in storage order, one per
// cycle when the sink keeps ready high, grouped into packets of ENTRIES_PER_PACKET;
// frames are not taken until the last entry sits in the output register. The table
// then counts as empty. The ram needs no clearing after reset.
module unique_mac_collector_batch_flush import umc_pkg::*; #(
    parameter int unsigned TABLE_DEPTH        = UMC_TABLE_DEPTH,
    parameter int unsigned ENTRIES_PER_PACKET = UMC_ENTRIES_PER_PACKET
) (
    input  logic         clk,
    input  logic         rst_n,
    umc_frame_if.sink    frames,
    umc_entry_if.source  entries
);

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned POS_W = (ENTRIES_PER_PACKET > 1) ? $clog2(ENTRIES_PER_PACKET) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_APPEND = 4'b0100,
        S_FLUSH  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic                 pend_reg, pend_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;

    // emit-side counters for the flush
    logic [CNT_W-1:0]     emit_reg, emit_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [PKT_NUM_W-1:0] pkt_reg, pkt_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;
    logic [PKT_NUM_W-1:0] out_pkt_reg, out_pkt_next;
    logic                 out_chain_reg, out_chain_next;
    logic                 out_lpkt_reg, out_lpkt_next;
    logic                 out_lfl_reg, out_lfl_next;

    // ram ports
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    ram_rdata;

    logic                 in_xfer;
    logic                 rd_more;
    logic                 load_out;
    logic                 last_flush;
    logic                 last_pkt;

    umc_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (addr_reg),
        .re    (ram_re),
        .raddr (idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign frames.ready = (state_reg == S_IDLE);
    assign in_xfer      = frames.valid && frames.ready;

    // flush metadata for the entry moving into the output register
    assign last_flush = (emit_reg == CNT_W'(TABLE_DEPTH - 1));
    assign last_pkt   = (pos_reg == POS_W'(ENTRIES_PER_PACKET - 1)) || last_flush;
    assign load_out   = (state_reg == S_FLUSH) && pend_reg
                        && (!out_valid_reg || entries.ready);

    // read side limit: search stops at count, flush at depth
    assign rd_more = (state_reg == S_SEARCH) ? (idx_reg < count_reg)
                                             : (idx_reg < CNT_W'(TABLE_DEPTH));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pend_next  = pend_reg;
        addr_next  = addr_reg;
        emit_next  = emit_reg;
        pos_next   = pos_reg;
        pkt_next   = pkt_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (frames.frame_type != FT_EXTENSION))
                begin
                    addr_next  = frames.source_address;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (pend_reg && (ram_rdata == addr_reg))
                begin
                    state_next = S_IDLE;
                end
                else if (!rd_more)
                begin
                    pend_next  = 1'b0;
                    state_next = S_APPEND;
                end
                else
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            S_APPEND:
            begin
                ram_we = 1'b1;
                if (count_reg == CNT_W'(TABLE_DEPTH - 1))
                begin
                    count_next = '0;
                    idx_next   = '0;
                    pend_next  = 1'b0;
                    emit_next  = '0;
                    pos_next   = '0;
                    pkt_next   = '0;
                    state_next = S_FLUSH;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                if (rd_more && (!pend_reg || load_out))
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
                else if (load_out)
                begin
                    pend_next = 1'b0;
                end
                if (load_out)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (last_pkt)
                    begin
                        pos_next = '0;
                        pkt_next = pkt_reg + 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                    if (last_flush)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_addr_next  = out_addr_reg;
        out_pkt_next   = out_pkt_reg;
        out_chain_next = out_chain_reg;
        out_lpkt_next  = out_lpkt_reg;
        out_lfl_next   = out_lfl_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_addr_next  = ram_rdata;
            out_pkt_next   = pkt_reg;
            out_chain_next = (pkt_reg != '0);
            out_lpkt_next  = last_pkt;
            out_lfl_next   = last_flush;
        end
        else if (entries.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            emit_reg      <= '0;
            pos_reg       <= '0;
            pkt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            emit_reg      <= emit_next;
            pos_reg       <= pos_next;
            pkt_reg       <= pkt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        out_addr_reg  <= out_addr_next;
        out_pkt_reg   <= out_pkt_next;
        out_chain_reg <= out_chain_next;
        out_lpkt_reg  <= out_lpkt_next;
        out_lfl_reg   <= out_lfl_next;
    end

    assign entries.valid          = out_valid_reg;
    assign entries.entry_address  = out_addr_reg;
    assign entries.packet_number  = out_pkt_reg;
    assign entries.chained_flag   = out_chain_reg;
    assign entries.last_in_packet = out_lpkt_reg;
    assign entries.last_of_flush  = out_lfl_reg;

endmodule

// ===== rtl/core/umc_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module umc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/umc_checker.sv =====
// port-level checks for the unique address collector, bound to the top level
module umc_checker import umc_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [PKT_NUM_W-1:0] packet_number,
    input logic                 chained_flag,
    input logic                 last_in_packet,
    input logic                 last_of_flush
);

    // a stalled entry stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("entry dropped while stalled");

    // chained exactly when the packet is not the first
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (chained_flag == (packet_number != '0)))
        else $error("chained flag disagrees with packet number");

    // end of flush also closes its packet
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_of_flush |-> last_in_packet)
        else $error("flush ended inside an open packet");

    // no frame is taken in the middle of a flush
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_flush |-> !in_ready)
        else $error("frame taken during flush");

endmodule

bind unique_mac_collector_batch_flush umc_checker u_umc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (frames.ready),
    .out_valid      (entries.valid),
    .out_ready      (entries.ready),
    .packet_number  (entries.packet_number),
    .chained_flag   (entries.chained_flag),
    .last_in_packet (entries.last_in_packet),
    .last_of_flush  (entries.last_of_flush)
);

// ===== tb/umc_checker.sv =====
// checker for the unique address collector: tracks the table, predicts flushes, compares
module umc_scoreboard import umc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    umc_frame_if frames,
    umc_entry_if entries,
    output int   mismatches,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0]    address;
        logic [PKT_NUM_W-1:0] packet_number;
        logic                 chained;
        logic                 last_in_packet;
        logic                 last_of_flush;
    } flushed_entry_t;

    // shadow copy of the distinct-address table
    logic [ADDR_W-1:0] known_addresses[UMC_TABLE_DEPTH];
    int unsigned       known_count;
    flushed_entry_t    flush_queue[$];

    initial begin
        mismatches = 0;
        pending    = 0;
    end

    task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                   logic [ADDR_W-1:0] want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    // search the table, append a new address, queue the flush when it fills
    function automatic void absorb_frame(frame_type_t ftype, logic [ADDR_W-1:0] addr);
        flushed_entry_t e;
        int unsigned    pkt;
        if (ftype == FT_EXTENSION)
            return;
        for (int unsigned i = 0; i < known_count; i++)
            if (known_addresses[i] == addr)
                return;
        known_addresses[known_count] = addr;
        known_count++;
        if (known_count == UMC_TABLE_DEPTH)
        begin
            for (int unsigned i = 0; i < UMC_TABLE_DEPTH; i++)
            begin
                pkt              = i / UMC_ENTRIES_PER_PACKET;
                e.address        = known_addresses[i];
                e.packet_number  = PKT_NUM_W'(pkt);
                e.chained        = (pkt != 0);
                e.last_of_flush  = (i == UMC_TABLE_DEPTH - 1);
                e.last_in_packet = (i % UMC_ENTRIES_PER_PACKET == UMC_ENTRIES_PER_PACKET - 1)
                                   || e.last_of_flush;
                flush_queue.push_back(e);
            end
            known_count = 0;
        end
    endfunction

    // compare one flushed entry with the oldest prediction
    task automatic check_entry();
        flushed_entry_t want;
        if (flush_queue.size() == 0)
        begin
            report_mismatch("entry_address (nothing expected)", entries.entry_address, '0);
            return;
        end
        want = flush_queue.pop_front();
        if (entries.entry_address !== want.address)
            report_mismatch("entry_address", entries.entry_address, want.address);
        if (entries.packet_number !== want.packet_number)
            report_mismatch("packet_number", ADDR_W'(entries.packet_number),
                            ADDR_W'(want.packet_number));
        if (entries.chained_flag !== want.chained)
            report_mismatch("chained_flag", ADDR_W'(entries.chained_flag),
                            ADDR_W'(want.chained));
        if (entries.last_in_packet !== want.last_in_packet)
            report_mismatch("last_in_packet", ADDR_W'(entries.last_in_packet),
                            ADDR_W'(want.last_in_packet));
        if (entries.last_of_flush !== want.last_of_flush)
            report_mismatch("last_of_flush", ADDR_W'(entries.last_of_flush),
                            ADDR_W'(want.last_of_flush));
    endtask

    // watch both channels; results first, then new frames
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_count = 0;
            flush_queue.delete();
            pending = 0;
        end
        else
        begin
            if (entries.valid && entries.ready)
                check_entry();
            if (frames.valid && frames.ready)
                absorb_frame(frames.frame_type, frames.source_address);
            pending = flush_queue.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// testbench top: clock, reset, frame stimulus, entry back-pressure and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import umc_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned DRAIN_CYCLES    = 2 * UMC_TABLE_DEPTH + 8;
    localparam int unsigned HOLD_OFF_CYCLES = 2000;
    localparam int unsigned RECENT_DEPTH    = 40;
    localparam int unsigned PHASE_ITEMS     = 53;

    logic        clk;
    logic        rst_n;
    int          mismatches;
    int          pending;
    int unsigned stall_pct = 0;
    logic        hold_off  = 1'b0;

    // addresses sent lately, reused to hit the known-address path
    logic [ADDR_W-1:0] recent_addresses[$];

    umc_frame_if frames();
    umc_entry_if entries();

    unique_mac_collector_batch_flush u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frames),
        .entries (entries)
    );

    umc_scoreboard u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .frames     (frames),
        .entries    (entries),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // receiver: random stalls, or a long hold-off
    initial
    begin
        entries.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
                entries.ready <= 1'b0;
            else
                entries.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one frame after random idle cycles, return once the transfer happened
    task automatic send_frame(frame_type_t ftype, logic [ADDR_W-1:0] addr,
                              int unsigned idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            frames.valid <= 1'b0;
            @(negedge clk);
        end
        frames.valid          <= 1'b1;
        frames.frame_type     <= ftype;
        frames.source_address <= addr;
        @(posedge clk);
        while (!frames.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly fresh addresses, some repeats of recent ones, a few corner values
    task automatic pick_frame(input bit fresh_only, output frame_type_t ftype,
                              output logic [ADDR_W-1:0] addr);
        int unsigned roll;
        roll  = $urandom_range(99);
        ftype = (roll < 12) ? FT_EXTENSION : frame_type_t'($urandom_range(2));
        roll  = $urandom_range(99);
        if (fresh_only || roll < 72 || recent_addresses.size() == 0)
            addr = ADDR_W'({$urandom(), $urandom()});
        else if (roll < 94)
            addr = recent_addresses[$urandom_range(recent_addresses.size() - 1)];
        else
        begin
            case ($urandom_range(2))
                0:       addr = '0;
                1:       addr = '1;
                default: addr = ADDR_W'(1) << $urandom_range(ADDR_W - 1);
            endcase
        end
        recent_addresses.push_back(addr);
        if (recent_addresses.size() > RECENT_DEPTH)
            void'(recent_addresses.pop_front());
    endtask

    task automatic run_phase(int unsigned count, int unsigned idle_pct,
                             int unsigned recv_pct, bit fresh_only);
        frame_type_t       ftype;
        logic [ADDR_W-1:0] addr;
        stall_pct <= recv_pct;
        for (int unsigned k = 0; k < count; k++)
        begin
            pick_frame(fresh_only, ftype, addr);
            send_frame(ftype, addr, idle_pct);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        frames.valid          = 1'b0;
        frames.frame_type     = FT_MANAGEMENT;
        frames.source_address = '0;
        rst_n                 = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every type, dropped extension, known address, extreme values
        send_frame(FT_MANAGEMENT, 48'h0000_0000_0000, 0);
        send_frame(FT_CONTROL,    48'hffff_ffff_ffff, 0);
        send_frame(FT_DATA,       48'h0000_0000_0000, 0);
        send_frame(FT_EXTENSION,  48'h1234_5678_9abc, 0);
        send_frame(FT_DATA,       48'h1234_5678_9abc, 0);
        send_frame(FT_EXTENSION,  48'hffff_ffff_ffff, 0);
        send_frame(FT_MANAGEMENT, 48'haaaa_aaaa_aaaa, 0);
        send_frame(FT_CONTROL,    48'h5555_5555_5555, 0);
        send_frame(FT_DATA,       48'h8000_0000_0000, 0);
        send_frame(FT_MANAGEMENT, 48'h0000_0000_0001, 0);
        send_frame(FT_CONTROL,    48'haaaa_aaaa_aaaa, 0);
        send_frame(FT_MANAGEMENT, 48'hffff_ffff_ffff, 0);

        // random phases: no idling, sender idle, receiver stalling, both lightly
        run_phase(PHASE_ITEMS, 0,  0,  1'b0);
        run_phase(PHASE_ITEMS, 77, 0,  1'b0);
        run_phase(PHASE_ITEMS, 0,  77, 1'b0);
        run_phase(PHASE_ITEMS, 7,  7,  1'b0);

        // long receiver hold-off while fresh frames keep coming, so a flush backs up
        fork
            begin
                @(posedge clk);
                hold_off <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        run_phase(PHASE_ITEMS, 0, 0, 1'b1);

        frames.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
